/* hdl/tbca_pkg.sv */
// Shared types, constants and command/status structs for the time bin channel averager.
package tbca_pkg;

  // Default sizing for the top-level parameters
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 16;

  // Fixed field widths
  localparam int TIME_W   = 63;
  localparam int BIN_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int PERIOD_W = 32;
  localparam int NCH_W    = 5;
  localparam int CH_W     = 4;

  // Register reset values: one second of microseconds, all channels active
  localparam int unsigned MICROS_PER_SECOND = 1000000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(MICROS_PER_SECOND * 1);
  localparam logic [NCH_W-1:0]    NUM_CH_RESET = NCH_W'(16);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 1'd1;

  // Shared divider geometry: 64-bit dividend, 32-bit divisor, one bit a cycle
  localparam int DIV_N_W   = 64;
  localparam int DIV_D_W   = 32;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Channel store read address source
  typedef enum logic [1:0] {
    RD_PORT  = 2'd0,
    RD_LATCH = 2'd1,
    RD_INDEX = 2'd2
  } rd_src_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    in_load;
    logic    rd_en;
    rd_src_t rd_src;
    logic    acc_write;
    logic    idx_clear;
    logic    idx_inc;
    logic    div_start_avg;
    logic    div_start_ceil;
    logic    out_load;
    logic    bin_adv;
    logic    bin_ceil_load;
    logic    ch_clear;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mapped;
    logic flush_hit;
    logic bin_started;
    logic idx_done;
    logic cnt_zero;
    logic div_busy;
    logic late;
    logic out_free;
  } status_t;

endpackage

/* hdl/time_bin_channel_averager.sv */
// Top level of the time bin channel averager: controller, datapath and checks.
//
// Values are summed and counted per channel over bins of period_us microseconds.
// An ordinary value is read, then its channel's sum and count are written back
// in the channel store. The first value of a sample that reaches the bin end
// starts a flush: each active channel is read and, if not empty, its average is
// found by the 64-step one-bit-per-cycle divider; the result register may then
// wait on out_stall. Then the bin end advances; when the time lies past the
// advanced end, the ceiling is found with the same divider; then the value is
// read and accumulated. The very first value also uses the divider to compute
// its bin end. Reset clears the channel store at once through per-entry
// valid bits, so there is no clearing pass.
module time_bin_channel_averager #(
  parameter int MAX_CHANNELS = tbca_pkg::MAX_CHANNELS_DEF,
  parameter int COUNT_BITS   = tbca_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tbca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbca_pkg::PERIOD_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mapped,
  input  logic                                first_of_sample,
  input  logic [tbca_pkg::TIME_W-1:0]         time_us,
  input  logic [tbca_pkg::CH_W-1:0]           channel,
  input  logic signed [tbca_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tbca_pkg::CH_W-1:0]           out_channel,
  output logic signed [tbca_pkg::VALUE_W-1:0] average,
  output logic                                empty_res,
  output logic [tbca_pkg::TIME_W-1:0]         centre_time_us,
  output logic                                last
);

  tbca_pkg::cmd_t    cmd;
  tbca_pkg::status_t st;

  tbca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tbca_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mapped          (mapped),
    .first_of_sample (first_of_sample),
    .time_us         (time_us),
    .channel         (channel),
    .value           (value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_channel     (out_channel),
    .average         (average),
    .empty_res       (empty_res),
    .centre_time_us  (centre_time_us),
    .last            (last),
    .cmd             (cmd),
    .st              (st)
  );

  // Accepting a mapped beat always makes the block go busy
  a_mapped_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mapped) |=> in_stall)
    else $error("mapped beat accepted without the block going busy");

  // Results only appear in the middle of a flush
  a_out_in_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_stall)
    else $error("result raised while the block was idle");

  // The divider is never left running when a new beat can be taken
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !st.div_busy)
    else $error("divider busy while the block is idle");

endmodule

/* hdl/tbca_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module tbca_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tbca_pkg::DIV_N_W-1:0]     num,
  input  logic [tbca_pkg::DIV_D_W-1:0]     den,
  output logic                             busy,
  output logic [tbca_pkg::DIV_N_W-1:0]     quo,
  output logic [tbca_pkg::DIV_D_W-1:0]     rem
);

  logic [tbca_pkg::DIV_CNT_W-1:0] cnt;
  logic [tbca_pkg::DIV_D_W-1:0]   den_q;
  logic [tbca_pkg::DIV_D_W:0]     part;
  logic [tbca_pkg::DIV_D_W:0]     diff;
  logic                           ge;

  // Trial subtract of the divisor from the shifted partial remainder
  assign part = {rem, quo[tbca_pkg::DIV_N_W-1]};
  assign diff = part - {1'b0, den_q};
  assign ge   = !diff[tbca_pkg::DIV_D_W];

  // Track the run
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == tbca_pkg::DIV_CNT_W'(tbca_pkg::DIV_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  // Load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
      cnt   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[tbca_pkg::DIV_D_W-1:0] : part[tbca_pkg::DIV_D_W-1:0];
      quo <= {quo[tbca_pkg::DIV_N_W-2:0], ge};
      cnt <= cnt + tbca_pkg::DIV_CNT_W'(1);
    end
  end

endmodule

/* hdl/tbca_datapath.sv */
// Datapath: configuration, bin end, per-channel sum/count store, divider and result register.
module tbca_datapath #(
  parameter int MAX_CHANNELS = tbca_pkg::MAX_CHANNELS_DEF,
  parameter int COUNT_BITS   = tbca_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tbca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbca_pkg::PERIOD_W-1:0]       cfg_data,
  input  logic                                mapped,
  input  logic                                first_of_sample,
  input  logic [tbca_pkg::TIME_W-1:0]         time_us,
  input  logic [tbca_pkg::CH_W-1:0]           channel,
  input  logic signed [tbca_pkg::VALUE_W-1:0] value,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [tbca_pkg::CH_W-1:0]           out_channel,
  output logic signed [tbca_pkg::VALUE_W-1:0] average,
  output logic                                empty_res,
  output logic [tbca_pkg::TIME_W-1:0]         centre_time_us,
  output logic                                last,
  input  tbca_pkg::cmd_t                      cmd,
  output tbca_pkg::status_t                   st
);

  localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DEPTH = 1 << AW;
  localparam int IDXW  = $clog2(MAX_CHANNELS + 1);
  localparam int EW    = (IDXW > tbca_pkg::NCH_W) ? IDXW : tbca_pkg::NCH_W;
  localparam int SW    = tbca_pkg::VALUE_W + COUNT_BITS;
  localparam int CW    = COUNT_BITS;

  // Configuration registers
  logic [tbca_pkg::PERIOD_W-1:0] period_us;
  logic [tbca_pkg::NCH_W-1:0]    num_channels;

  // Bin state and latched input beat
  logic [tbca_pkg::BIN_W-1:0]         bin_end;
  logic [tbca_pkg::TIME_W-1:0]        t_lat;
  logic [tbca_pkg::CH_W-1:0]          ch_lat;
  logic signed [tbca_pkg::VALUE_W-1:0] val_lat;
  logic [tbca_pkg::BIN_W-1:0]         ceil_num;

  // Channel store
  logic signed [SW-1:0] sum_mem [DEPTH];
  logic [CW-1:0]        cnt_mem [DEPTH];
  logic [DEPTH-1:0]     ent_vld;
  logic signed [SW-1:0] rd_sum;
  logic [CW-1:0]        rd_cnt;
  logic                 rd_vld;

  logic [IDXW-1:0] idx;

  logic [tbca_pkg::PERIOD_W-1:0] p_eff;
  logic [EW-1:0]                 num_ext;
  logic [EW-1:0]                 max_ext;
  logic [EW-1:0]                 nch_eff;
  logic [EW-1:0]                 idx_ext;
  logic [EW-1:0]                 ch_lat_ext;
  logic [AW+tbca_pkg::CH_W-1:0]  port_ch_wide;
  logic [AW+tbca_pkg::CH_W-1:0]  lat_ch_wide;
  logic [AW-1:0]                 port_addr;
  logic [AW-1:0]                 lat_addr;
  logic [AW-1:0]                 idx_addr;
  logic [AW-1:0]                 rd_addr;
  logic signed [SW-1:0]          sum_q;
  logic [CW-1:0]                 cnt_q;
  logic                          sum_neg;
  logic [SW-1:0]                 mag;
  logic                          acc_en;
  logic [tbca_pkg::BIN_W-1:0]    ceil_num_next;
  logic [tbca_pkg::BIN_W-1:0]    centre;
  logic                          last_flag;

  logic                          div_start;
  logic [tbca_pkg::DIV_N_W-1:0]  div_num;
  logic [tbca_pkg::DIV_D_W-1:0]  div_den;
  logic                          div_busy;
  logic [tbca_pkg::DIV_N_W-1:0]  div_quo;
  logic [tbca_pkg::DIV_D_W-1:0]  div_rem;
  logic [tbca_pkg::VALUE_W-1:0]  q_lo;
  logic [tbca_pkg::VALUE_W-1:0]  avg_val;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_us    <= tbca_pkg::PERIOD_RESET;
      num_channels <= tbca_pkg::NUM_CH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tbca_pkg::REG_PERIOD_US:    period_us    <= cfg_data;
        tbca_pkg::REG_NUM_CHANNELS: num_channels <= cfg_data[tbca_pkg::NCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective period and active channel count
  assign p_eff   = (period_us == '0) ? tbca_pkg::PERIOD_W'(1) : period_us;
  assign num_ext = EW'(num_channels);
  assign max_ext = EW'(MAX_CHANNELS);
  assign nch_eff = (num_ext > max_ext) ? max_ext : num_ext;

  // Store addresses
  assign port_ch_wide = (AW + tbca_pkg::CH_W)'(channel);
  assign lat_ch_wide  = (AW + tbca_pkg::CH_W)'(ch_lat);
  assign port_addr    = port_ch_wide[AW-1:0];
  assign lat_addr     = lat_ch_wide[AW-1:0];
  assign idx_ext      = EW'(idx);
  assign idx_addr     = idx_ext[AW-1:0];
  assign ch_lat_ext   = EW'(ch_lat);

  always_comb begin
    case (cmd.rd_src)
      tbca_pkg::RD_PORT:  rd_addr = port_addr;
      tbca_pkg::RD_LATCH: rd_addr = lat_addr;
      tbca_pkg::RD_INDEX: rd_addr = idx_addr;
      default:            rd_addr = port_addr;
    endcase
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      t_lat   <= time_us;
      ch_lat  <= channel;
      val_lat <= value;
    end
  end

  // Read one channel entry; entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_sum <= sum_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
      rd_vld <= ent_vld[rd_addr];
    end
  end

  assign sum_q = rd_vld ? rd_sum : '0;
  assign cnt_q = rd_vld ? rd_cnt : '0;

  // Accumulate into an active channel until its count saturates
  assign acc_en = cmd.acc_write && (ch_lat_ext < nch_eff) && (cnt_q != '1);

  always_ff @(posedge clk) begin
    if (acc_en) begin
      sum_mem[lat_addr] <= sum_q + SW'(val_lat);
      cnt_mem[lat_addr] <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (cmd.ch_clear) begin
      ent_vld <= '0;
    end else if (acc_en) begin
      ent_vld[lat_addr] <= 1'b1;
    end
  end

  // Flush channel index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDXW'(1);
    end
  end

  assign last_flag = (EW'(idx_ext + EW'(1)) == nch_eff);

  // Divider operands: magnitude of the sum over the count, or the ceiling remainder
  assign sum_neg       = sum_q[SW-1];
  assign mag           = sum_neg ? (~sum_q + SW'(1)) : sum_q;
  assign ceil_num_next = tbca_pkg::BIN_W'(t_lat) + tbca_pkg::BIN_W'(p_eff - tbca_pkg::PERIOD_W'(1));
  assign div_start     = cmd.div_start_avg || cmd.div_start_ceil;
  assign div_num       = cmd.div_start_ceil ? ceil_num_next : tbca_pkg::DIV_N_W'(mag);
  assign div_den       = cmd.div_start_ceil ? p_eff : tbca_pkg::DIV_D_W'(cnt_q);

  always_ff @(posedge clk) begin
    if (cmd.div_start_ceil) begin
      ceil_num <= ceil_num_next;
    end
  end

  tbca_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Restore the sign of the truncated quotient
  assign q_lo    = div_quo[tbca_pkg::VALUE_W-1:0];
  assign avg_val = sum_neg ? (~q_lo + tbca_pkg::VALUE_W'(1)) : q_lo;

  // Advance the bin end, or jump it to the ceiling of the latched time
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_end <= '0;
    end else if (cmd.bin_adv) begin
      bin_end <= bin_end + tbca_pkg::BIN_W'(p_eff);
    end else if (cmd.bin_ceil_load) begin
      bin_end <= ceil_num - tbca_pkg::BIN_W'(div_rem);
    end
  end

  assign centre = bin_end - tbca_pkg::BIN_W'(p_eff >> 1);

  // Result register: hold while stalled, reload when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel    <= idx_ext[tbca_pkg::CH_W-1:0];
      average        <= (cnt_q == '0) ? '0 : avg_val;
      empty_res      <= (cnt_q == '0);
      centre_time_us <= centre[tbca_pkg::TIME_W-1:0];
      last           <= last_flag;
    end
  end

  // Status toward the controller
  always_comb begin
    st.mapped      = mapped;
    st.flush_hit   = first_of_sample && (tbca_pkg::BIN_W'(time_us) >= bin_end);
    st.bin_started = (bin_end != '0);
    st.idx_done    = (idx_ext >= nch_eff);
    st.cnt_zero    = (cnt_q == '0);
    st.div_busy    = div_busy;
    st.late        = (tbca_pkg::BIN_W'(t_lat) > bin_end);
    st.out_free    = !out_valid || !out_stall;
  end

endmodule

/* hdl/tbca_ctrl.sv */
// Controller state machine: accumulate, flush, bin advance and ceiling sequencing.
module tbca_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tbca_pkg::status_t  st,
  output tbca_pkg::cmd_t     cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_ACC       = 10'b0000000010,
    S_RD        = 10'b0000000100,
    S_FL_RD     = 10'b0000001000,
    S_FL_CHK    = 10'b0000010000,
    S_FL_WAIT   = 10'b0000100000,
    S_FL_OUT    = 10'b0001000000,
    S_BIN_ADV   = 10'b0010000000,
    S_BIN_CHK   = 10'b0100000000,
    S_CEIL_WAIT = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   ceil_go;
  logic   ceil_go_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ceil_go <= 1'b0;
    end else begin
      state   <= state_next;
      ceil_go <= ceil_go_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd          = '0;
    state_next   = state;
    ceil_go_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = tbca_pkg::RD_PORT;
          if (!st.mapped) begin
            state_next = S_IDLE;
          end else if (st.flush_hit) begin
            if (st.bin_started) begin
              cmd.idx_clear = 1'b1;
              state_next    = S_FL_RD;
            end else begin
              ceil_go_next = 1'b1;
              state_next   = S_CEIL_WAIT;
            end
          end else begin
            state_next = S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.acc_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = tbca_pkg::RD_LATCH;
        state_next = S_ACC;
      end
      S_FL_RD: begin
        if (st.idx_done) begin
          state_next = S_BIN_ADV;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = tbca_pkg::RD_INDEX;
          state_next = S_FL_CHK;
        end
      end
      S_FL_CHK: begin
        if (st.cnt_zero) begin
          state_next = S_FL_OUT;
        end else begin
          cmd.div_start_avg = 1'b1;
          state_next        = S_FL_WAIT;
        end
      end
      S_FL_WAIT: begin
        if (!st.div_busy) begin
          state_next = S_FL_OUT;
        end
      end
      S_FL_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_next   = S_FL_RD;
        end
      end
      S_BIN_ADV: begin
        cmd.bin_adv = 1'b1;
        state_next  = S_BIN_CHK;
      end
      S_BIN_CHK: begin
        if (st.late) begin
          ceil_go_next = 1'b1;
          state_next   = S_CEIL_WAIT;
        end else begin
          cmd.ch_clear = 1'b1;
          state_next   = S_RD;
        end
      end
      S_CEIL_WAIT: begin
        // kick the divider on entry, then wait for the remainder
        if (ceil_go) begin
          cmd.div_start_ceil = 1'b1;
        end else if (!st.div_busy) begin
          cmd.bin_ceil_load = 1'b1;
          cmd.ch_clear      = 1'b1;
          state_next        = S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
